>>> rtl/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = ADDR_W + 2;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        status_t            status;
        logic [6:0]         count;
    } out_item_t;

endpackage

>>> rtl/bhq_ram.sv
// ----------------------------------------------------------------------------
// bhq_ram
// Simple memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> rtl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-heap priority queue in one dual-read memory: insert sifts up,
// extract returns the root and sifts the last entry down.
//
//   channel  dir  ports                      payload
//   s_       in   s_valid, s_ready, s_data   action, value
//   m_       out  m_valid, m_ready, m_data   out_value, status, count
//
// One item at a time. Insert climbs and extract descends one level per
// step; each level costs one memory read and one write-back. Full or
// empty items skip the memory. Reset clears the state, the entry count
// and the output valid only. A waiting result does not block the next
// transfer in; a finished item holds until the output register is free.
// ----------------------------------------------------------------------------
module binary_max_heap_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bhq_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bhq_pkg::out_item_t  m_data
);

    localparam int AW = bhq_pkg::ADDR_W;
    localparam int CW = bhq_pkg::CNT_W;
    localparam int MW = bhq_pkg::CMP_W;
    localparam int KW = bhq_pkg::KEY_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_RD  = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_EX_LD  = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_HOLD   = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic signed [KW-1:0]    key_reg, key_next;
    logic signed [KW-1:0]    res_value_reg, res_value_next;
    bhq_pkg::status_t        res_status_reg, res_status_next;
    logic                    m_valid_reg, m_valid_next;
    bhq_pkg::out_item_t      m_data_reg, m_data_next;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [KW-1:0]           wr_data;
    logic [AW-1:0]           rd_addr_a, rd_addr_b;
    logic [KW-1:0]           rd_data_a, rd_data_b;

    logic                    s_xfer;
    logic                    out_free;
    logic [AW-1:0]           parent;
    logic [MW-1:0]           left_idx, right_idx, n_ext;
    logic                    left_ok, right_ok, pick_right;
    logic signed [KW-1:0]    child_val;
    logic [AW-1:0]           child_idx;

    bhq_ram #(
        .DEPTH (bhq_pkg::CAPACITY),
        .WIDTH (KW)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign parent     = (pos_reg - AW'(1)) >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + MW'(1);
    assign n_ext      = MW'(count_reg);
    assign left_ok    = left_idx < n_ext;
    assign right_ok   = right_idx < n_ext;
    assign pick_right = right_ok && ($signed(rd_data_b) > $signed(rd_data_a));
    assign child_val  = pick_right ? $signed(rd_data_b) : $signed(rd_data_a);
    assign child_idx  = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = key_reg;
        rd_addr_a       = AW'(0);
        rd_addr_b       = AW'(count_reg - CW'(1));

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    res_value_next  = '0;
                    res_status_next = bhq_pkg::STATUS_OK;
                    if (s_data.action == bhq_pkg::ACT_INSERT) begin
                        if (count_reg >= CW'(bhq_pkg::CAPACITY)) begin
                            res_status_next = bhq_pkg::STATUS_FULL;
                            state_next      = S_HOLD;
                        end else begin
                            pos_next   = count_reg[AW-1:0];
                            key_next   = s_data.value;
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = bhq_pkg::STATUS_EMPTY;
                            state_next      = S_HOLD;
                        end else begin
                            count_next = count_reg - CW'(1);
                            state_next = S_EX_LD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                rd_addr_a = parent;
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = S_HOLD;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if ($signed(rd_data_a) < key_reg) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data_a;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end else begin
                    wr_en      = 1'b1;
                    state_next = S_HOLD;
                end
            end
            S_EX_LD: begin
                res_value_next = $signed(rd_data_a);
                key_next       = $signed(rd_data_b);
                pos_next       = '0;
                state_next     = S_DN_RD;
            end
            S_DN_RD: begin
                rd_addr_a = left_idx[AW-1:0];
                rd_addr_b = right_idx[AW-1:0];
                if (left_ok) begin
                    state_next = S_DN_CMP;
                end else begin
                    wr_en      = 1'b1;
                    state_next = S_HOLD;
                end
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (child_val > key_reg) begin
                    wr_data    = child_val;
                    pos_next   = child_idx;
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_value = res_value_reg;
                    m_data_next.status    = res_status_reg;
                    m_data_next.count     = 7'(count_reg);
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the max-heap priority queue. A shadow heap predicts
// value, status and count for every accepted transfer. Directed items cover
// key extremes, duplicates, extract on empty and draining to zero. Random
// phases then fill, drain and mix operations, with idle gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    typedef struct {
        bhq_pkg::in_item_t item;
        int unsigned       gap;
        bit                hold;
    } heap_op_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bhq_pkg::in_item_t   s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bhq_pkg::out_item_t  m_data;

    heap_op_t            pending_ops[$];
    bhq_pkg::out_item_t  expected_results[$];
    int unsigned gap_cnt      = 0;
    int unsigned stall_cnt    = 0;
    bit          rx_calm      = 1'b0;
    int unsigned accepted_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned err_cnt      = 0;
    int          gen_fill     = 0;

    logic signed [31:0] shadow_heap[bhq_pkg::CAPACITY];
    int                 shadow_fill = 0;

    binary_max_heap_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bhq_pkg::out_item_t heap_apply(input bhq_pkg::in_item_t it);
        bhq_pkg::out_item_t res;
        int                 pos;
        int                 parent;
        int                 left;
        int                 right;
        int                 largest;
        logic signed [31:0] tmp;
        res.out_value = '0;
        res.status    = bhq_pkg::STATUS_OK;
        if (it.action == bhq_pkg::ACT_INSERT) begin
            if (shadow_fill >= bhq_pkg::CAPACITY) begin
                res.status = bhq_pkg::STATUS_FULL;
            end else begin
                pos = shadow_fill;
                shadow_heap[pos] = it.value;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (shadow_heap[parent] < shadow_heap[pos]) begin
                        tmp                 = shadow_heap[parent];
                        shadow_heap[parent] = shadow_heap[pos];
                        shadow_heap[pos]    = tmp;
                        pos                 = parent;
                    end else begin
                        break;
                    end
                end
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                res.status = bhq_pkg::STATUS_EMPTY;
            end else begin
                res.out_value = shadow_heap[0];
                shadow_fill--;
                shadow_heap[0] = shadow_heap[shadow_fill];
                pos = 0;
                forever begin
                    left    = 2 * pos + 1;
                    right   = left + 1;
                    largest = pos;
                    if (left < shadow_fill && shadow_heap[left] > shadow_heap[largest])
                        largest = left;
                    if (right < shadow_fill && shadow_heap[right] > shadow_heap[largest])
                        largest = right;
                    if (largest == pos) break;
                    tmp                  = shadow_heap[pos];
                    shadow_heap[pos]     = shadow_heap[largest];
                    shadow_heap[largest] = tmp;
                    pos                  = largest;
                end
            end
        end
        res.count = 7'(shadow_fill);
        return res;
    endfunction

    task automatic queue_op(input logic act, input logic [31:0] val,
                            input int unsigned gap, input bit hold);
        heap_op_t op;
        op.item.action = act;
        op.item.value  = val;
        op.gap         = gap;
        op.hold        = hold;
        pending_ops.push_back(op);
        if (act == bhq_pkg::ACT_INSERT && gen_fill < bhq_pkg::CAPACITY) gen_fill++;
        if (act == bhq_pkg::ACT_EXTRACT && gen_fill > 0) gen_fill--;
    endtask

    function automatic logic [31:0] draw_key(input int pattern);
        logic [31:0] v;
        case (pattern)
            0: v = $urandom;
            1: v = 32'($signed($urandom_range(0, 15)) - 8);
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0000_0001;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // driver
    always @(posedge aclk) begin : drive
        logic present;
        logic took;
        present = s_valid;
        took    = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(heap_apply(s_data));
                accepted_cnt <= accepted_cnt + 1;
                present = 1'b0;
                took    = 1'b1;
            end
            if (!present && pending_ops.size() != 0) begin
                if (pending_ops[0].hold && (took || accepted_cnt != results_seen)) begin
                    gap_cnt <= 0;
                end else if (gap_cnt < pending_ops[0].gap) begin
                    gap_cnt <= gap_cnt + 1;
                end else begin
                    s_data  <= pending_ops[0].item;
                    void'(pending_ops.pop_front());
                    gap_cnt <= 0;
                    present = 1'b1;
                end
            end
            s_valid <= present;
        end
    end

    // monitor
    always @(posedge aclk) begin : watch
        bhq_pkg::out_item_t want;
        int unsigned        w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else if (m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result: value %0d status %0d count %0d",
                       m_data.out_value, m_data.status, m_data.count);
                err_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.out_value !== want.out_value) begin
                    $error("out_value: expected %0d, actual %0d",
                           want.out_value, m_data.out_value);
                    err_cnt++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    err_cnt++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, m_data.count);
                    err_cnt++;
                end
            end
            if ($urandom_range(0, 15) == 0) rx_calm <= !rx_calm;
            w = rx_calm ? 0 : $urandom_range(0, 4);
            m_ready   <= (w == 0);
            stall_cnt <= w;
        end else if (!m_ready) begin
            if (stall_cnt <= 1) m_ready <= 1'b1;
            stall_cnt <= (stall_cnt == 0) ? 0 : stall_cnt - 1;
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned total;
        int unsigned len;
        int          mode;
        int          pat;
        bit          calm;
        bit          ins;
        logic [31:0] val;

        queue_op(bhq_pkg::ACT_EXTRACT, 32'hFFFF_FFFF, 0, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h7FFF_FFFF, 0, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h8000_0000, 1, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h0000_0000, 0, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'hFFFF_FFFF, 2, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h0000_0001, 0, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h0000_0005, 0, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h0000_0005, 3, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h0000_0005, 0, 1'b1);
        for (int i = 0; i < 8; i++)
            queue_op(bhq_pkg::ACT_EXTRACT, $urandom, i % 3, i == 4);
        queue_op(bhq_pkg::ACT_EXTRACT, 32'h0000_0000, 0, 1'b0);
        queue_op(bhq_pkg::ACT_INSERT,  32'h8000_0000, 0, 1'b0);
        queue_op(bhq_pkg::ACT_EXTRACT, 32'h7FFF_FFFF, 4, 1'b0);

        total = 0;
        while (total < 1030) begin
            mode = $urandom_range(0, 4);
            pat  = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            case (mode)
                3:       len = bhq_pkg::CAPACITY - gen_fill + 2;
                4:       len = gen_fill + 2;
                default: len = $urandom_range(20, 70);
            endcase
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0:       ins = ($urandom_range(0, 9) < 8);
                    1:       ins = ($urandom_range(0, 9) < 2);
                    2:       ins = $urandom_range(0, 1);
                    3:       ins = 1'b1;
                    default: ins = 1'b0;
                endcase
                val = ins ? draw_key(pat) : $urandom;
                queue_op(ins ? bhq_pkg::ACT_INSERT : bhq_pkg::ACT_EXTRACT, val,
                         calm ? 0 : $urandom_range(0, 4),
                         k == 0 && $urandom_range(0, 2) == 0);
                total++;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid || accepted_cnt != results_seen)
            @(negedge aclk);
        repeat (50) @(posedge aclk);

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
